// ===== design/sli_pkg.sv =====
// Shared types and constants for the sorted key list.
// Used by sli_cell and sorted_list_insert_delete; depends on nothing.
package sli_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Fixed port field widths
    localparam int CMD_W     = 2;
    localparam int KEY_IN_W  = 32;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int RKEY_W    = 32;
    localparam int ECOUNT_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef logic [KEY_W-1:0] key_t;

    // Operation broadcast to every cell for one item
    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic cmp_signed;
        key_t key;
    } cell_op_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic valid;
        key_t entry;
    } cell_link_t;

    // Flags rippling along the row
    typedef struct packed {
        logic stop_seen;   // insert point lies at or before this cell
        logic found;       // delete match lies at or before this cell
        logic rd_hit;      // read selected a held entry
        key_t rd_data;     // entry read, zero when no hit
    } cell_chain_t;

endpackage

// ===== design/sli_cell.sv =====
// One cell of the sorted key list: holds one entry and its valid bit.
// Depends on sli_pkg for the op, link and chain types.
module sli_cell
    import sli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_op_t    op,
    input  logic        rd_sel,
    input  cell_link_t  left,
    input  cell_link_t  right,
    input  cell_chain_t chain_in,
    output cell_link_t  self,
    output cell_chain_t chain_out
);

    logic valid_reg, valid_next;
    key_t entry_reg, entry_next;
    key_t key_cmp, entry_cmp;
    logic greater, stop_here, match_here;

    assign key_cmp   = op.cmp_signed ? (op.key ^ {1'b1, {(KEY_W-1){1'b0}}}) : op.key;
    assign entry_cmp = op.cmp_signed ? (entry_reg ^ {1'b1, {(KEY_W-1){1'b0}}}) : entry_reg;
    assign greater    = key_cmp > entry_cmp;
    assign stop_here  = !valid_reg || !greater;
    assign match_here = valid_reg && (entry_reg == op.key);

    assign chain_out.stop_seen = chain_in.stop_seen || stop_here;
    assign chain_out.found     = chain_in.found || match_here;
    assign chain_out.rd_hit    = chain_in.rd_hit || (rd_sel && valid_reg);
    assign chain_out.rd_data   = chain_in.rd_data | ((rd_sel && valid_reg) ? entry_reg : '0);

    assign self.valid = valid_reg;
    assign self.entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (op.ins_en) begin
            if (chain_in.stop_seen) begin
                // shift up: take the left neighbor
                valid_next = left.valid;
                entry_next = left.entry;
            end else if (stop_here) begin
                valid_next = 1'b1;
                entry_next = op.key;
            end
        end else if (op.del_en) begin
            if (chain_in.found || match_here) begin
                // shift down: take the right neighbor
                valid_next = right.valid;
                entry_next = right.entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// Sorted key list: top level with stream ports, count and output register.
// Depends on sli_pkg and instantiates a row of LIST_DEPTH sli_cell cells.
// m_tvalid rises the cycle after accept; one item per cycle unless m_tready stalls.
// The cycle is set by the row of cells: insert point, delete match and read hit
// ripple cell to cell while every cell compares its entry against the key.
// Reset (aresetn low, synchronous) empties the list, selects unsigned compare and
// drops any pending result; entry contents are not cleared.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: compare_signed
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    // command items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] key, [35:32] index, rest zero
    input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] read_key, [36:32] entry_count
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    logic                 cmp_signed_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg;
    status_t              m_status_reg, status_next;
    logic [RKEY_W-1:0]    m_rkey_reg, rkey_next;
    logic [ECOUNT_W-1:0]  m_count_reg;

    logic                 s_accept;
    cmd_t                 cmd;
    logic [KEY_IN_W-1:0]  key_in;
    logic [INDEX_W-1:0]   index_in;
    logic                 full;
    cell_op_t             op;

    cell_link_t           links   [LIST_DEPTH];
    cell_chain_t          chains  [LIST_DEPTH+1];
    logic [LIST_DEPTH-1:0] valid_vec;

    // Unpack the input item
    assign cmd      = cmd_t'(s_tuser);
    assign key_in   = s_tdata[KEY_IN_W-1:0];
    assign index_in = s_tdata[KEY_IN_W +: INDEX_W];

    // Accept whenever the output register is free or being emptied
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign full = links[LIST_DEPTH-1].valid;

    // Broadcast the operation; a full list takes no insert
    assign op.ins_en     = s_accept && (cmd == CMD_INSERT) && !full;
    assign op.del_en     = s_accept && (cmd == CMD_DELETE);
    assign op.cmp_signed = cmp_signed_reg;
    assign op.key        = KEY_W'(key_in);

    assign chains[0].stop_seen = 1'b0;
    assign chains[0].found     = 1'b0;
    assign chains[0].rd_hit    = 1'b0;
    assign chains[0].rd_data   = '0;

    // Row of cells, cell 0 holds the smallest entry
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        cell_link_t left_l, right_l;
        logic       sel;

        if (i == 0) begin : g_first
            assign left_l.valid = 1'b1;
            assign left_l.entry = '0;
        end else begin : g_mid_l
            assign left_l = links[i-1];
        end

        if (i == LIST_DEPTH-1) begin : g_last
            assign right_l.valid = 1'b0;
            assign right_l.entry = '0;
        end else begin : g_mid_r
            assign right_l = links[i+1];
        end

        assign sel = (32'(index_in) == i);
        assign valid_vec[i] = links[i].valid;

        sli_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .rd_sel    (sel),
            .left      (left_l),
            .right     (right_l),
            .chain_in  (chains[i]),
            .self      (links[i]),
            .chain_out (chains[i+1])
        );
    end

    // Result of the accepted item
    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        rkey_next   = '0;
        case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (chains[LIST_DEPTH].found) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (chains[LIST_DEPTH].rd_hit) begin
                    rkey_next = RKEY_W'(chains[LIST_DEPTH].rd_data);
                end else begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default: begin
                // unused command: no change, ok status
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_signed_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cmp_signed_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_status_reg <= status_next;
            m_rkey_reg   <= rkey_next;
            m_count_reg  <= ECOUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W-RKEY_W-ECOUNT_W){1'b0}}, m_count_reg, m_rkey_reg};

    // Count tracks the number of valid cells
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) == $countones(valid_vec))
        else $error("count disagrees with cell valid bits");

    // Valid cells form an unbroken run from cell 0
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + LIST_DEPTH'(1))) == '0)
        else $error("gap in valid cells");

    // A successful insert grows the list by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        op.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // A delete that misses leaves every cell untouched
    a_miss_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.del_en && !chains[LIST_DEPTH].found) |=> $stable(valid_vec))
        else $error("missed delete changed the list");

endmodule
